/* sv/tpcc_pkg.sv */
// Shared constants, event codes and control/status structs for the
// two-phase commit coordinator. No dependencies.
`default_nettype none

package tpcc_pkg;

  localparam int TXN_SLOTS = 16;
  localparam int NODES     = 16;

  localparam int TXN_W  = 4;
  localparam int NODE_W = 4;
  localparam int MASK_W = 16;
  localparam int CNT_W  = $clog2(MASK_W + 1);

  localparam logic [MASK_W-1:0] NODE_MASK = MASK_W'((64'd1 << NODES) - 64'd1);

  localparam logic [1:0] CMD_BEGIN   = 2'd0;
  localparam logic [1:0] CMD_VOTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [1:0] ST_ONGOING   = 2'd0;
  localparam logic [1:0] ST_COMMITTED = 2'd1;
  localparam logic [1:0] ST_ABORTED   = 2'd2;

  localparam logic [2:0] EV_INVALID     = 3'd0;
  localparam logic [2:0] EV_VOTE        = 3'd1;
  localparam logic [2:0] EV_TIMEOUT     = 3'd2;
  localparam logic [2:0] EV_ABORTED     = 3'd3;
  localparam logic [2:0] EV_COMMITTED   = 3'd4;
  localparam logic [2:0] EV_ROLLBACK    = 3'd5;
  localparam logic [2:0] EV_COMMIT_NODE = 3'd6;
  localparam logic [2:0] EV_ROLLED_BACK = 3'd7;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       known;
    logic       finished;
    logic       vote;
    logic       complete;
    logic       rem_empty;
    logic       rem_one;
  } tpcc_stat_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       load;
    logic       wr_begin;
    logic       wr_abort;
    logic       wr_vote;
    logic       scan_load;
    logic       scan_step;
    logic       emit;
    logic [2:0] ev;
    logic       last;
  } tpcc_ctl_t;

endpackage

`default_nettype wire

/* sv/tpcc_ctrl.sv */
// Sequencer for the two-phase commit coordinator: walks each transaction
// through lookup, table update and event emission. Depends on tpcc_pkg.
`default_nettype none

module tpcc_ctrl
  import tpcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  var  tpcc_stat_t stat,
  output tpcc_ctl_t       ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_INVAL = 3'd3;
  localparam logic [2:0] S_FIRST = 3'd4;
  localparam logic [2:0] S_HEAD  = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_TAIL  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ongoing;
  logic       is_abort;
  logic       more;

  assign ongoing  = stat.known && !stat.finished;
  assign is_abort = (stat.cmd == CMD_TIMEOUT) || !stat.vote;
  // anything after the vote/timeout event: abort or a completed commit
  assign more     = ongoing && (is_abort || stat.complete);
  assign busy     = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        ctl.load  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        ctl.scan_load = 1'b1;
        priority if (stat.cmd == CMD_BEGIN) begin
          ctl.wr_begin = 1'b1;
          state_nxt    = S_IDLE;
        end else if (stat.cmd == CMD_VOTE || stat.cmd == CMD_TIMEOUT) begin
          if (ongoing) begin
            ctl.wr_abort = is_abort;
            ctl.wr_vote  = !is_abort;
          end
          state_nxt = stat.known ? S_FIRST : S_INVAL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INVAL: begin
        ctl.emit  = 1'b1;
        ctl.ev    = EV_INVALID;
        ctl.last  = (stat.cmd == CMD_TIMEOUT);
        state_nxt = (stat.cmd == CMD_TIMEOUT) ? S_IDLE : S_FIRST;
      end
      S_FIRST: begin
        ctl.emit  = 1'b1;
        ctl.ev    = (stat.cmd == CMD_VOTE) ? EV_VOTE : EV_TIMEOUT;
        ctl.last  = !more;
        state_nxt = more ? S_HEAD : S_IDLE;
      end
      S_HEAD: begin
        ctl.emit = 1'b1;
        ctl.ev   = is_abort ? EV_ABORTED : EV_COMMITTED;
        ctl.last = !is_abort && stat.rem_empty;
        if (stat.rem_empty) begin
          state_nxt = is_abort ? S_TAIL : S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.emit      = 1'b1;
        ctl.scan_step = 1'b1;
        ctl.ev        = is_abort ? EV_ROLLBACK : EV_COMMIT_NODE;
        ctl.last      = !is_abort && stat.rem_one;
        if (stat.rem_one) begin
          state_nxt = is_abort ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        ctl.emit  = 1'b1;
        ctl.ev    = EV_ROLLED_BACK;
        ctl.last  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/tpcc_dpath.sv */
// Datapath for the two-phase commit coordinator: command registers, slot
// table, vote counting, participant scan and event output registers.
// Depends on tpcc_pkg.
`default_nettype none

module tpcc_dpath
  import tpcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  var  tpcc_ctl_t         ctl,
  output tpcc_stat_t             stat,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [TXN_W-1:0]  in_txn_id,
  input  wire logic [NODE_W-1:0] in_node_id,
  input  wire logic              in_commit_vote,
  input  wire logic [MASK_W-1:0] in_participant_mask,
  output logic                   out_valid,
  output logic [2:0]             out_event_res,
  output logic [TXN_W-1:0]       out_event_txn,
  output logic [NODE_W-1:0]      out_event_node,
  output logic                   out_event_vote,
  output logic                   out_last
);

  function automatic logic [CNT_W-1:0] popcnt(input logic [MASK_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  // captured transaction
  logic [1:0]        cmd_r;
  logic [TXN_W-1:0]  txn_r;
  logic [NODE_W-1:0] node_r;
  logic              vote_r;
  logic [MASK_W-1:0] pmask_r;

  // slot table; only the valid bits need reset
  logic              tbl_valid_r  [TXN_SLOTS];
  logic [1:0]        tbl_status_r [TXN_SLOTS];
  logic [MASK_W-1:0] tbl_parts_r  [TXN_SLOTS];
  logic [MASK_W-1:0] tbl_votes_r  [TXN_SLOTS];

  // working copy of the addressed slot
  logic              known_r;
  logic              fin_r;
  logic [MASK_W-1:0] wparts_r;
  logic [MASK_W-1:0] wvotes_r;
  logic [MASK_W-1:0] rem_r;

  logic              in_table;
  logic [MASK_W-1:0] vote_bit;
  logic              complete;
  logic [NODE_W-1:0] scan_idx;
  logic [MASK_W-1:0] rem_clr;

  logic              out_valid_r;
  logic [2:0]        out_ev_r;
  logic [TXN_W-1:0]  out_txn_r;
  logic [NODE_W-1:0] out_node_r;
  logic              out_vote_r;
  logic              out_last_r;

  assign in_table = (32'(txn_r) < TXN_SLOTS);
  assign vote_bit = (32'(node_r) < NODES) ? (MASK_W'(1) << node_r) : '0;
  assign complete = (popcnt(wvotes_r) == popcnt(wparts_r));
  assign rem_clr  = rem_r & (rem_r - MASK_W'(1));

  // lowest remaining participant
  always_comb begin
    scan_idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        scan_idx = NODE_W'(i);
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.known     = known_r;
    stat.finished  = fin_r;
    stat.vote      = vote_r;
    stat.complete  = complete;
    stat.rem_empty = (rem_r == '0);
    stat.rem_one   = (rem_r != '0) && (rem_clr == '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= in_cmd;
      txn_r   <= in_txn_id;
      node_r  <= in_node_id;
      vote_r  <= in_commit_vote;
      pmask_r <= in_participant_mask;
    end
    if (ctl.load) begin
      known_r  <= in_table && tbl_valid_r[txn_r];
      fin_r    <= (tbl_status_r[txn_r] != ST_ONGOING);
      wparts_r <= tbl_parts_r[txn_r];
      wvotes_r <= tbl_votes_r[txn_r] | vote_bit;
    end
    if (ctl.scan_load) begin
      rem_r <= wparts_r;
    end else if (ctl.scan_step) begin
      rem_r <= rem_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TXN_SLOTS; i++) begin
        tbl_valid_r[i] <= 1'b0;
      end
    end else if (ctl.wr_begin && in_table) begin
      tbl_valid_r[txn_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_begin && in_table) begin
      tbl_status_r[txn_r] <= ST_ONGOING;
      tbl_parts_r[txn_r]  <= pmask_r & NODE_MASK;
      tbl_votes_r[txn_r]  <= '0;
    end
    if (ctl.wr_abort) begin
      tbl_status_r[txn_r] <= ST_ABORTED;
    end
    if (ctl.wr_vote) begin
      tbl_votes_r[txn_r] <= wvotes_r;
      if (complete) begin
        tbl_status_r[txn_r] <= ST_COMMITTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_ev_r   <= ctl.ev;
      out_txn_r  <= txn_r;
      out_last_r <= ctl.last;
      out_vote_r <= (ctl.ev == EV_VOTE) ? vote_r : 1'b0;
      if (ctl.ev == EV_VOTE) begin
        out_node_r <= node_r;
      end else if (ctl.ev == EV_ROLLBACK || ctl.ev == EV_COMMIT_NODE) begin
        out_node_r <= scan_idx;
      end else begin
        out_node_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_ev_r;
  assign out_event_txn  = out_txn_r;
  assign out_event_node = out_node_r;
  assign out_event_vote = out_vote_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* sv/two_phase_commit_coordinator.sv */
// Top level of the two-phase commit coordinator: sequencer plus datapath.
// Depends on tpcc_pkg, tpcc_ctrl and tpcc_dpath.
`default_nettype none

// A transaction is taken when start is high and busy is low. The block then
// looks up the slot, updates the table and emits its events one per cycle
// from an output register; out_valid marks each event for a single cycle and
// out_last flags the final one. The receiver cannot stall, so every strobed
// event must be taken. busy stays high through lookup, update and emission of
// the N events (0 to 19) that the transaction causes; a begin causes none.
// The event count is set by the participant scan, which emits one node event
// per cycle.
module two_phase_commit_coordinator
  import tpcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [TXN_W-1:0]  in_txn_id,
  input  wire logic [NODE_W-1:0] in_node_id,
  input  wire logic              in_commit_vote,
  input  wire logic [MASK_W-1:0] in_participant_mask,
  output logic                   out_valid,
  output logic [2:0]             out_event_res,
  output logic [TXN_W-1:0]       out_event_txn,
  output logic [NODE_W-1:0]      out_event_node,
  output logic                   out_event_vote,
  output logic                   out_last
);

  tpcc_ctl_t  ctl;
  tpcc_stat_t stat;

  tpcc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  tpcc_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .stat                (stat),
    .in_cmd              (in_cmd),
    .in_txn_id           (in_txn_id),
    .in_node_id          (in_node_id),
    .in_commit_vote      (in_commit_vote),
    .in_participant_mask (in_participant_mask),
    .out_valid           (out_valid),
    .out_event_res       (out_event_res),
    .out_event_txn       (out_event_txn),
    .out_event_node      (out_event_node),
    .out_event_vote      (out_event_vote),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

/* sv/tpcc_chk.sv */
// Port-level checker for the two-phase commit coordinator, bound to the
// top level. Depends on tpcc_pkg and two_phase_commit_coordinator.
`default_nettype none

module tpcc_chk
  import tpcc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [2:0]        out_event_res,
  input wire logic [NODE_W-1:0] out_event_node,
  input wire logic              out_event_vote,
  input wire logic              out_last
);

  // a transaction's events come back to back
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("event stream of a transaction broken");

  // more events pending means the block must still be busy
  a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("not busy while events still pending");

  // the next transaction needs lookup and update before any event
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("event right after last event");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_VOTE && out_event_res != EV_ROLLBACK &&
    out_event_res != EV_COMMIT_NODE |-> out_event_node == '0 && !out_event_vote)
    else $error("node or vote set on an event without one");

endmodule

bind two_phase_commit_coordinator tpcc_chk u_tpcc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_event_res  (out_event_res),
  .out_event_node (out_event_node),
  .out_event_vote (out_event_vote),
  .out_last       (out_last)
);

`default_nettype wire
